// ===== design/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared sizes, element-kind codes, states and compare functions for the
// selection sort and search block.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int KIND_W = 2;
    localparam int OUT_W  = 40;

    localparam logic [KIND_W-1:0] KIND_S32 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_S8  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_F32 = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_SCAN,
        ST_SWAP,
        ST_EMIT,
        ST_SRCH,
        ST_ANS
    } t_state;

    function automatic logic is_nan(input logic [VAL_W-1:0] x);
        return x[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic is_zero(input logic [VAL_W-1:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // order-preserving key for ieee single
    function automatic logic [VAL_W-1:0] f_key(input logic [VAL_W-1:0] x);
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    function automatic logic less_than(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b,
                                       input logic [KIND_W-1:0] kind);
        logic res;
        case (kind)
            KIND_S8:  res = $signed(a[7:0]) < $signed(b[7:0]);
            KIND_F32: begin
                if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) begin
                    res = 1'b0;
                end else begin
                    res = f_key(a) < f_key(b);
                end
            end
            default:  res = $signed(a) < $signed(b);
        endcase
        return res;
    endfunction

    function automatic logic equal_to(input logic [VAL_W-1:0] a,
                                      input logic [VAL_W-1:0] b,
                                      input logic [KIND_W-1:0] kind);
        logic res;
        case (kind)
            KIND_S8:  res = a[7:0] == b[7:0];
            KIND_F32: begin
                if (is_nan(a) || is_nan(b)) begin
                    res = 1'b0;
                end else if (is_zero(a) && is_zero(b)) begin
                    res = 1'b1;
                end else begin
                    res = a == b;
                end
            end
            default:  res = a == b;
        endcase
        return res;
    endfunction

endpackage

// ===== design/sss_ram.sv =====
// ----------------------------------------------------------------------------
// sss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/selection_sort_and_search.sv =====
// ----------------------------------------------------------------------------
// selection_sort_and_search
// Loads a set into a RAM, sorts it in place by selection sort, streams the
// sorted run out and answers linear-search membership queries.
// ----------------------------------------------------------------------------
// element word: a non-closing element is accepted again on the next cycle
// sort of N elements: pass i runs PASS, a SCAN over entries i to N-1, SWAP and
//   EMIT; the scan compares one element per cycle, set by the single RAM read port
// first sorted word is registered out by EMIT of the first pass, which waits on a stall
// search: linear scan of the finished set, stops early on a hit
// reset: synchronous, active low; clears count, flags, kind; RAM not cleared
module selection_sort_and_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: element kind
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sss_pkg::KIND_W-1:0]   i_cfg_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [sss_pkg::VAL_W-1:0]    s_axis_tdata,  // [31:0] value
    input  logic                         s_axis_tuser,  // [0] req_type
    input  logic                         s_axis_tlast,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [sss_pkg::OUT_W-1:0]    m_axis_tdata,  // [31:0] sorted_value,
                                                        // [32] found, [33] overflow
    output logic                         m_axis_tuser,  // [0] result_kind
    output logic                         m_axis_tlast
);

    localparam int AW = sss_pkg::ADDR_W;
    localparam int CW = sss_pkg::CNT_W;
    localparam int VW = sss_pkg::VAL_W;

    sss_pkg::t_state r_state, n_state;

    logic [sss_pkg::KIND_W-1:0] r_kind;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_ovf, n_ovf;
    logic                       r_set_done, n_set_done;
    logic [AW-1:0]              r_i, n_i;
    logic [AW-1:0]              r_rd, n_rd;
    logic [AW-1:0]              r_pos, n_pos;
    logic [VW-1:0]              r_cur, n_cur;
    logic [VW-1:0]              r_min, n_min;
    logic [VW-1:0]              r_key, n_key;
    logic                       r_hit, n_hit;

    logic                       r_out_valid, n_out_valid;
    logic [sss_pkg::OUT_W-1:0]  r_out_data, n_out_data;
    logic                       r_out_user, n_out_user;
    logic                       r_out_last, n_out_last;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VW-1:0]              ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [VW-1:0]              ram_rdata;

    logic                       in_acc;
    logic                       out_free;
    logic [CW-1:0]              rd_nxt;
    logic                       scan_more;
    logic                       i_last;
    logic [CW-1:0]              eff_count;
    logic                       can_store;
    logic                       lt;
    logic                       eq;
    logic [VW-1:0]              emit_val;

    sss_ram #(
        .WIDTH (VW),
        .DEPTH (sss_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == sss_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign out_free  = ~r_out_valid | m_axis_tready;
    assign rd_nxt    = CW'(r_rd) + CW'(1);
    assign scan_more = rd_nxt < r_count;
    assign i_last    = (CW'(r_i) + CW'(1)) == r_count;
    // a new element after a finished set starts a fresh one
    assign eff_count = r_set_done ? '0 : r_count;
    assign can_store = eff_count < CW'(sss_pkg::DEPTH);
    assign lt        = sss_pkg::less_than(ram_rdata, r_min, r_kind);
    assign eq        = sss_pkg::equal_to(r_key, ram_rdata, r_kind);
    assign emit_val  = (r_kind == sss_pkg::KIND_S8) ? {24'd0, r_min[7:0]} : r_min;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sss_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        n_state = r_set_done ? sss_pkg::ST_SRCH : sss_pkg::ST_ANS;
                    end else if (s_axis_tlast) begin
                        n_state = sss_pkg::ST_PASS;
                    end
                end
            end
            sss_pkg::ST_PASS: n_state = sss_pkg::ST_SCAN;
            sss_pkg::ST_SCAN: begin
                if (!scan_more) begin
                    n_state = sss_pkg::ST_SWAP;
                end
            end
            sss_pkg::ST_SWAP: n_state = sss_pkg::ST_EMIT;
            sss_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = i_last ? sss_pkg::ST_IDLE : sss_pkg::ST_PASS;
                end
            end
            sss_pkg::ST_SRCH: begin
                if (eq || !scan_more) begin
                    n_state = sss_pkg::ST_ANS;
                end
            end
            sss_pkg::ST_ANS: begin
                if (out_free) begin
                    n_state = sss_pkg::ST_IDLE;
                end
            end
            default: n_state = sss_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_set_done  = r_set_done;
        n_i         = r_i;
        n_rd        = r_rd;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_min       = r_min;
        n_key       = r_key;
        n_hit       = r_hit;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_i;
        ram_wdata   = r_min;
        ram_raddr   = rd_nxt[AW-1:0];

        unique case (r_state)
            sss_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        n_key     = s_axis_tdata;
                        n_hit     = 1'b0;
                        ram_raddr = '0;
                        n_rd      = '0;
                    end else begin
                        n_set_done = 1'b0;
                        if (r_set_done) begin
                            n_ovf = 1'b0;
                        end
                        if (can_store) begin
                            ram_we    = 1'b1;
                            ram_waddr = eff_count[AW-1:0];
                            ram_wdata = s_axis_tdata;
                            n_count   = eff_count + CW'(1);
                        end else begin
                            n_count = eff_count;
                            n_ovf   = 1'b1;
                        end
                        n_i = '0;
                    end
                end
            end
            sss_pkg::ST_PASS: begin
                ram_raddr = r_i;
                n_rd      = r_i;
            end
            sss_pkg::ST_SCAN: begin
                // first word of a pass is the entry at the pass position
                if (r_rd == r_i) begin
                    n_cur = ram_rdata;
                    n_min = ram_rdata;
                    n_pos = r_i;
                end else if (lt) begin
                    n_min = ram_rdata;
                    n_pos = r_rd;
                end
                if (scan_more) begin
                    n_rd = rd_nxt[AW-1:0];
                end
            end
            sss_pkg::ST_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_cur;
            end
            sss_pkg::ST_EMIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = r_min;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = 1'b0;
                    n_out_data  = {6'd0, r_ovf, 1'b0, emit_val};
                    n_out_last  = i_last;
                    if (i_last) begin
                        n_set_done = 1'b1;
                    end else begin
                        n_i = AW'(CW'(r_i) + CW'(1));
                    end
                end
            end
            sss_pkg::ST_SRCH: begin
                n_hit = eq;
                if (scan_more) begin
                    n_rd = rd_nxt[AW-1:0];
                end
            end
            sss_pkg::ST_ANS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = 1'b1;
                    n_out_data  = {6'd0, r_ovf, r_hit, 32'd0};
                    n_out_last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sss_pkg::ST_IDLE;
            r_kind      <= sss_pkg::KIND_S32;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_set_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_set_done  <= n_set_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_kind <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_rd       <= n_rd;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_min      <= n_min;
        r_key      <= n_key;
        r_hit      <= n_hit;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

endmodule

// ===== design/sss_check.sv =====
// ----------------------------------------------------------------------------
// sss_check
// Port-level checks for selection_sort_and_search, bound to the top level.
// ----------------------------------------------------------------------------
module sss_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic                      s_axis_tuser,
    input  logic                      s_axis_tlast,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [sss_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                      m_axis_tuser,
    input  logic                      m_axis_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // a search answer is a single word with no value
    a_ans_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[31:0] == 32'd0))
        else $error("search answer malformed");

    // sorted words never carry a found flag
    a_sorted_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[32])
        else $error("found set on sorted word");

    // block is busy after a search key or the closing element
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast) |=>
            !s_axis_tready)
        else $error("input taken during sort or search");

endmodule

bind selection_sort_and_search sss_check u_sss_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_selection_sort_and_search.sv =====
// ----------------------------------------------------------------------------
// tb_selection_sort_and_search
// Self-checking bench: loads random sets under every element kind, checks
// each sorted run and each search answer against a scoreboard that sorts
// and searches its own copy of the set, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_selection_sort_and_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_ELEM   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;
    localparam logic RES_SORTED = 1'b0;
    localparam logic RES_ANSWER = 1'b1;

    // unused kind code, compares as signed integer
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int STALL_PCT   = 58;
    localparam int BOTH_PCT    = 16;
    localparam int SETTLE      = 80;
    localparam int HOLD_OFF    = 800;
    localparam int QUIET_LIMIT = 6000;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        found;
        logic        ovf;
        logic        eor;
    } t_result;

    class sort_scoreboard;
        logic [31:0] store[sss_pkg::DEPTH];
        int          count;
        logic        ovf;
        logic        complete;
        logic [1:0]  kind;
        t_result     expected_q[$];
        int          errors;

        function new();
            count    = 0;
            ovf      = 1'b0;
            complete = 1'b0;
            kind     = sss_pkg::KIND_S32;
            errors   = 0;
        endfunction

        function void set_kind(logic [1:0] k);
            kind = k;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic nan_pat(logic [31:0] x);
            return x[30:0] > 31'h7F80_0000;
        endfunction

        function logic zero_pat(logic [31:0] x);
            return x[30:0] == 31'd0;
        endfunction

        // maps ieee single onto an unsigned ordering
        function logic [31:0] order_key(logic [31:0] x);
            return x[31] ? ~x : {1'b1, x[30:0]};
        endfunction

        function logic below(logic [31:0] a, logic [31:0] b);
            logic r;
            if (kind == sss_pkg::KIND_S8) begin
                r = $signed(a[7:0]) < $signed(b[7:0]);
            end else if (kind == sss_pkg::KIND_F32) begin
                if (nan_pat(a) || nan_pat(b) || (zero_pat(a) && zero_pat(b)))
                    r = 1'b0;
                else
                    r = order_key(a) < order_key(b);
            end else begin
                r = $signed(a) < $signed(b);
            end
            return r;
        endfunction

        function logic same(logic [31:0] a, logic [31:0] b);
            logic r;
            if (kind == sss_pkg::KIND_S8) begin
                r = a[7:0] == b[7:0];
            end else if (kind == sss_pkg::KIND_F32) begin
                if (nan_pat(a) || nan_pat(b))
                    r = 1'b0;
                else if (zero_pat(a) && zero_pat(b))
                    r = 1'b1;
                else
                    r = a == b;
            end else begin
                r = a == b;
            end
            return r;
        endfunction

        function void note_input(logic req, logic [31:0] v, logic last);
            t_result     r;
            int          i;
            int          j;
            int          pos;
            logic [31:0] minv;
            if (req == REQ_SEARCH) begin
                r.kind  = RES_ANSWER;
                r.value = '0;
                r.found = 1'b0;
                if (complete) begin
                    for (i = 0; i < count && !r.found; i++) begin
                        if (same(v, store[i]))
                            r.found = 1'b1;
                    end
                end
                r.ovf = ovf;
                r.eor = 1'b1;
                expected_q.push_back(r);
                return;
            end
            // a word after a finished set starts a new one
            if (complete) begin
                count    = 0;
                ovf      = 1'b0;
                complete = 1'b0;
            end
            if (count < sss_pkg::DEPTH) begin
                store[count] = v;
                count++;
            end else begin
                ovf = 1'b1;
            end
            if (!last)
                return;
            for (i = 0; i < count; i++) begin
                pos  = i;
                minv = store[i];
                for (j = i + 1; j < count; j++) begin
                    if (below(store[j], minv)) begin
                        minv = store[j];
                        pos  = j;
                    end
                end
                store[pos] = store[i];
                store[i]   = minv;
            end
            complete = 1'b1;
            for (i = 0; i < count; i++) begin
                r.kind  = RES_SORTED;
                r.value = (kind == sss_pkg::KIND_S8) ? {24'd0, store[i][7:0]} : store[i];
                r.found = 1'b0;
                r.ovf   = ovf;
                r.eor   = (i + 1 == count);
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic rkind, logic [sss_pkg::OUT_W-1:0] data,
                                   logic last);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word kind=%0b data=%h last=%0b",
                         $time, rkind, data, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (rkind !== e.kind) begin
                $display("%0t: result_kind expected %0b actual %0b", $time, e.kind, rkind);
                errors++;
            end
            if (data[31:0] !== e.value) begin
                $display("%0t: sorted_value expected %h actual %h",
                         $time, e.value, data[31:0]);
                errors++;
            end
            if (data[32] !== e.found) begin
                $display("%0t: found expected %0b actual %0b", $time, e.found, data[32]);
                errors++;
            end
            if (data[33] !== e.ovf) begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, data[33]);
                errors++;
            end
            if (last !== e.eor) begin
                $display("%0t: end_of_run expected %0b actual %0b", $time, e.eor, last);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [sss_pkg::KIND_W-1:0]  i_cfg_data;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [sss_pkg::VAL_W-1:0]   s_axis_tdata;   // [31:0] value
    logic                        s_axis_tuser;   // [0] req_type
    logic                        s_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [sss_pkg::OUT_W-1:0]   m_axis_tdata;   // [31:0] sorted_value, [32] found,
                                                 // [33] overflow
    logic                        m_axis_tuser;   // [0] result_kind
    logic                        m_axis_tlast;

    sort_scoreboard sb;
    logic [1:0]     cur_kind;
    bit             tx_idle;
    bit             rx_stall;
    int             idle_pct;
    int             rx_hold;
    int             quiet_cycles;
    int             sent;
    logic [31:0]    set_vals[$];
    bit             set_closed;

    selection_sort_and_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: long hold-off counted here, otherwise random stalls when rx_stall is set
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else if (rx_stall && $urandom_range(99) < idle_pct) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_selection_sort_and_search: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(logic req, logic [31:0] v, logic last);
        @(negedge i_clk);
        while (tx_idle && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(req, v, last);
        sent++;
        if (req == REQ_ELEM) begin
            if (set_closed)
                set_vals.delete();
            set_closed = last;
            set_vals.push_back(v);
        end
    endtask

    task automatic tx_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        tx_quiet();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_kind(logic [1:0] k);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_kind(k);
        cur_kind = k;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] specials[13] = '{
            32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
            32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
            32'h0000_007F, 32'h0000_0080, 32'h3F80_0000, 32'hBF80_0000,
            32'h0000_0001};
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom();
            1: v = specials[$urandom_range(12)];
            2: v = $urandom_range(1) ? 32'($urandom_range(6)) : -32'($urandom_range(6));
            default: v = {24'($urandom_range(32'hFF_FFFF)),
                          specials[$urandom_range(12)][7:0]};
        endcase
        return v;
    endfunction

    // half the keys come from the set, reshaped so that equal-but-different
    // patterns also hit
    function automatic logic [31:0] pick_key();
        logic [31:0] v;
        if (set_vals.size() != 0 && $urandom_range(1)) begin
            v = set_vals[$urandom_range(set_vals.size() - 1)];
            if (cur_kind == sss_pkg::KIND_S8 && $urandom_range(1))
                v[31:8] = 24'($urandom());
            if (cur_kind == sss_pkg::KIND_F32 && v[30:0] == 31'd0)
                v[31] = 1'($urandom_range(1));
        end else begin
            v = pick_value();
        end
        return v;
    endfunction

    task automatic send_set(int n);
        int i;
        for (i = 0; i < n; i++)
            send_word(REQ_ELEM, pick_value(), i == n - 1);
    endtask

    task automatic random_traffic(int n_items);
        int stop;
        int r;
        int i;
        int n;
        stop = sent + n_items;
        while (sent < stop) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_word(REQ_SEARCH, pick_key(), 1'($urandom_range(1)));
            end else if (r < 14) begin
                // set left open, searched mid-load
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    send_word(REQ_ELEM, pick_value(), 1'b0);
                send_word(REQ_SEARCH, pick_key(), 1'b0);
            end else begin
                n = (r < 17) ? $urandom_range(sss_pkg::DEPTH, sss_pkg::DEPTH + 3)
                             : $urandom_range(1, 8);
                send_set(n);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    send_word(REQ_SEARCH, pick_key(), 1'($urandom_range(1)));
            end
            if ($urandom_range(3) == 0)
                tx_quiet();
        end
    endtask

    initial begin
        logic [1:0] phase_kind[8] = '{sss_pkg::KIND_F32, sss_pkg::KIND_S8, KIND_SPARE,
                                      sss_pkg::KIND_S32, sss_pkg::KIND_F32,
                                      sss_pkg::KIND_S8, sss_pkg::KIND_F32,
                                      sss_pkg::KIND_S32};
        int p;
        sb            = new();
        cur_kind      = sss_pkg::KIND_S32;
        tx_idle       = 1'b0;
        rx_stall      = 1'b0;
        idle_pct      = STALL_PCT;
        rx_hold       = 0;
        quiet_cycles  = 0;
        sent          = 0;
        set_closed    = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ELEM;
        s_axis_tlast  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // signed integer extremes, duplicates, search before any set
        write_kind(sss_pkg::KIND_S32);
        send_word(REQ_SEARCH, 32'h0000_0000, 1'b0);
        send_word(REQ_SEARCH, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_ELEM, 32'h7FFF_FFFF, 1'b0);
        send_word(REQ_ELEM, 32'h8000_0000, 1'b0);
        send_word(REQ_ELEM, 32'h0000_0000, 1'b0);
        send_word(REQ_ELEM, 32'hFFFF_FFFF, 1'b0);
        send_word(REQ_ELEM, 32'h0000_0005, 1'b0);
        send_word(REQ_ELEM, 32'h0000_0005, 1'b1);
        send_word(REQ_SEARCH, 32'h0000_0005, 1'b0);
        send_word(REQ_SEARCH, 32'h8000_0000, 1'b0);
        send_word(REQ_SEARCH, 32'h7FFF_FFFF, 1'b0);
        send_word(REQ_SEARCH, 32'h0000_0001, 1'b0);
        // search while a new set is loading sees nothing
        send_word(REQ_ELEM, 32'h0000_0003, 1'b0);
        send_word(REQ_SEARCH, 32'h0000_0003, 1'b0);
        send_word(REQ_ELEM, 32'h8000_0001, 1'b1);
        send_word(REQ_SEARCH, 32'h8000_0001, 1'b0);
        drain();

        // float: nan, signed zeros, infinity
        write_kind(sss_pkg::KIND_F32);
        send_word(REQ_ELEM, 32'h7FC0_0000, 1'b0);
        send_word(REQ_ELEM, 32'h8000_0000, 1'b0);
        send_word(REQ_ELEM, 32'h3F80_0000, 1'b0);
        send_word(REQ_ELEM, 32'hFF80_0000, 1'b0);
        send_word(REQ_ELEM, 32'h0000_0000, 1'b1);
        send_word(REQ_SEARCH, 32'h0000_0000, 1'b0);
        send_word(REQ_SEARCH, 32'h7FC0_0000, 1'b0);
        send_word(REQ_SEARCH, 32'hFF80_0000, 1'b0);
        drain();

        for (p = 0; p < 8; p++) begin
            tx_idle  = (p % 4 == 1) || (p % 4 == 3);
            rx_stall = (p % 4 == 2) || (p % 4 == 3);
            idle_pct = (p % 4 == 3) ? BOTH_PCT : STALL_PCT;
            write_kind(phase_kind[p]);
            random_traffic(4);
            drain();
        end

        // overfull set while the receiver holds off, searches back up the input
        tx_idle  = 1'b0;
        rx_stall = 1'b0;
        idle_pct = STALL_PCT;
        write_kind(sss_pkg::KIND_S8);
        send_set(sss_pkg::DEPTH + 2);
        rx_hold = HOLD_OFF;
        send_word(REQ_SEARCH, pick_key(), 1'b0);
        send_word(REQ_SEARCH, pick_key(), 1'b0);
        send_word(REQ_SEARCH, pick_value(), 1'b1);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_selection_sort_and_search: clean");
        end else begin
            if (sb.pending() != 0)
                $display("%0t: %0d expected words never arrived", $time, sb.pending());
            $display("tb_selection_sort_and_search: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sss_pkg.sv
design/sss_ram.sv
design/selection_sort_and_search.sv
design/sss_check.sv
test/tb_selection_sort_and_search.sv
